// ===== sv/npc_pkg.sv =====
// Shared types, constants and helpers for the near-plane triangle clipper.
// No dependencies; the top level, datapath and sequencer import this package.
package npc_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int DEPTH_FRAC    = 24;
    localparam int EPS_W         = 17;

    // configuration register indexes
    localparam logic REG_NEAR_EPS   = 1'b0;
    localparam logic REG_DEPTH_BIAS = 1'b1;

    localparam logic signed [31:0] I32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] I32_MIN = 32'sh80000000;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic [31:0]        c;
    } vertex_t;

    typedef enum logic [2:0] {
        COMP_X = 3'd0,
        COMP_Y = 3'd1,
        COMP_W = 3'd2,
        COMP_U = 3'd3,
        COMP_V = 3'd4
    } comp_t;

    typedef struct packed {
        logic       cut;
        logic [1:0] a;
        logic [1:0] b;
    } plan_t;

    typedef struct packed {
        logic       store_en;
        logic [1:0] store_slot;
        logic       rd_a;
        logic       rd_b;
        logic [1:0] rd_idx;
        logic       t_start;
        logic       mul_en;
        logic       add_en;
        comp_t      comp;
        logic       e_start;
        logic       out_load;
        logic       out_last;
    } npc_cmd_t;

    typedef struct packed {
        logic [2:0] mask;
        logic       t_done;
        logic       e_done;
        logic       out_free;
    } npc_stat_t;

    function automatic plan_t npc_cut(input logic [1:0] a, input logic [1:0] b);
        plan_t p;
        p.cut = 1'b1;
        p.a   = a;
        p.b   = b;
        return p;
    endfunction

    // What goes out at each slot for a given in-front mask: a stored vertex or an edge cut.
    function automatic plan_t npc_plan(input logic [2:0] mask, input logic [1:0] slot);
        plan_t p;
        p.cut = 1'b0;
        p.a   = slot;
        p.b   = slot;
        unique case ({mask, slot}) inside
            {3'd1, 2'd1}, {3'd5, 2'd1}, {3'd6, 2'd0}: p = npc_cut(2'd0, 2'd1);
            {3'd1, 2'd2}, {3'd3, 2'd2}, {3'd6, 2'd2}: p = npc_cut(2'd0, 2'd2);
            {3'd2, 2'd0}:                             p = npc_cut(2'd1, 2'd0);
            {3'd2, 2'd2}, {3'd3, 2'd3}, {3'd5, 2'd3}: p = npc_cut(2'd1, 2'd2);
            {3'd4, 2'd0}:                             p = npc_cut(2'd2, 2'd0);
            {3'd4, 2'd1}:                             p = npc_cut(2'd2, 2'd1);
            {3'd6, 2'd3}:
            begin
                p.a = 2'd2;
                p.b = 2'd2;
            end
            default: ;
        endcase
        return p;
    endfunction

    // last slot: quads for two vertices in front
    function automatic logic [1:0] npc_last(input logic [2:0] mask);
        return (mask == 3'd3 || mask == 3'd5 || mask == 3'd6) ? 2'd3 : 2'd2;
    endfunction

    // signed result from magnitude quotient, saturated
    function automatic logic signed [31:0] npc_sat_quo(input logic [32:0] q, input logic ovf,
                                                       input logic neg);
        logic signed [31:0] r;
        if (neg)
        begin
            if (ovf || q > 33'h080000000)
                r = I32_MIN;
            else
                r = -$signed(q[31:0]);
        end
        else
        begin
            if (ovf || q > 33'h07fffffff)
                r = I32_MAX;
            else
                r = $signed(q[31:0]);
        end
        return r;
    endfunction

    function automatic logic signed [31:0] npc_sat33(input logic signed [32:0] s);
        logic signed [31:0] r;
        if (s[32] != s[31])
            r = s[32] ? I32_MIN : I32_MAX;
        else
            r = s[31:0];
        return r;
    endfunction

endpackage

// ===== sv/near_plane_triangle_clipper.sv =====
// Top level of the near-plane triangle clipper: sequencer plus datapath.
// Depends on npc_pkg, npc_ctrl, npc_dp (and npc_div below it).
//
//   channel | direction | handshake              | beat
//   vert    | in        | vert_valid/vert_ready  | one clip-space vertex
//   res     | out       | res_valid/res_ready    | one screen vertex, end_of_strip on last
//   cfg     | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// The first two vertices of a triangle are taken one a cycle. After the third, each
// emitted vertex waits on the bit-serial dividers (edge weight when cut, then x, y and
// 1/w side by side). Reset clears the vertex phase, the configuration and the result
// valid; held vertices are not cleared. vert_ready is low from the third vertex until the
// triangle's last vertex sits in the result register (or none is in front); res_ready
// low holds that register.
module near_plane_triangle_clipper #(
    parameter int FRAC_BITS = npc_pkg::DEF_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vert_valid,
    output logic               vert_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] pos_w,
    input  logic signed [31:0] tex_u,
    input  logic signed [31:0] tex_v,
    input  logic [31:0]        color,
    output logic               res_valid,
    input  logic               res_ready,
    output logic signed [31:0] screen_x,
    output logic signed [31:0] screen_y,
    output logic signed [31:0] depth,
    output logic signed [31:0] out_u,
    output logic signed [31:0] out_v,
    output logic [31:0]        out_color,
    output logic               end_of_strip,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data
);

    import npc_pkg::*;

    npc_cmd_t  cmd;
    npc_stat_t stat;
    vertex_t   in_vtx;

    always_comb
    begin
        in_vtx.x = pos_x;
        in_vtx.y = pos_y;
        in_vtx.z = pos_z;
        in_vtx.w = pos_w;
        in_vtx.u = tex_u;
        in_vtx.v = tex_v;
        in_vtx.c = color;
    end

    assign cfg_ready = 1'b1;

    npc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .vert_valid (vert_valid),
        .vert_ready (vert_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    npc_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_vtx       (in_vtx),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .screen_x     (screen_x),
        .screen_y     (screen_y),
        .depth        (depth),
        .out_u        (out_u),
        .out_v        (out_v),
        .out_color    (out_color),
        .end_of_strip (end_of_strip)
    );

endmodule

// ===== sv/npc_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle, sticky overflow.
// Depends on nothing outside this file.
module npc_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32,
    parameter int QUO_W = 33
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [DEN_W-1:0] rem_init,
    output logic             done,
    output logic [QUO_W-1:0] quo,
    output logic             ovf
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] num_reg;
    logic [QUO_W-1:0] quo_reg;
    logic             ovf_reg;

    logic [DEN_W:0]   rem_sh;
    logic             fits;
    logic [DEN_W:0]   rem_diff;
    logic [DEN_W-1:0] rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[NUM_W-1]};
        fits     = rem_sh >= {1'b0, den_reg};
        rem_diff = rem_sh - {1'b0, den_reg};
        rem_next = fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            den_reg <= den;
            num_reg <= num;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            num_reg <= num_reg << 1;
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
            ovf_reg <= ovf_reg | quo_reg[QUO_W-1];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign ovf  = ovf_reg;

endmodule

// ===== sv/npc_dp.sv =====
// Clipper datapath: vertex store, edge weight, interpolation, perspective divide, result register.
// Depends on npc_pkg and npc_div.
module npc_dp #(
    parameter int FRAC_BITS = npc_pkg::DEF_FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  npc_pkg::npc_cmd_t   cmd,
    output npc_pkg::npc_stat_t  stat,
    input  logic                cfg_valid,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data,
    input  npc_pkg::vertex_t    in_vtx,
    output logic                res_valid,
    input  logic                res_ready,
    output logic signed [31:0]  screen_x,
    output logic signed [31:0]  screen_y,
    output logic signed [31:0]  depth,
    output logic signed [31:0]  out_u,
    output logic signed [31:0]  out_v,
    output logic [31:0]         out_color,
    output logic                end_of_strip
);

    import npc_pkg::*;

    localparam int NUM_W  = 32 + FRAC_BITS;
    localparam int ONE_W  = FRAC_BITS + 1;
    localparam int PROD_W = FRAC_BITS + 35;
    localparam logic [ONE_W-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [NUM_W-1:0] DEPTH_NUM = NUM_W'(1) << (DEPTH_FRAC + FRAC_BITS);

    logic [EPS_W-1:0]   eps_reg;
    logic signed [31:0] bias_reg;

    vertex_t store_reg [3];
    vertex_t op_a_reg;
    vertex_t op_b_reg;

    logic signed [31:0] wx_reg, wy_reg, ww_reg, wu_reg, wv_reg;
    logic [31:0]        wc_reg;

    logic               t_ge_reg;
    logic               t_cond_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic               res_valid_reg;
    logic signed [31:0] sx_reg, sy_reg, dep_reg, ou_reg, ov_reg;
    logic [31:0]        oc_reg;
    logic               eos_reg;

    logic signed [33:0] near_dist [3];
    logic [2:0]         front_mask;
    logic signed [33:0] da, db;
    logic signed [34:0] den;
    logic [33:0]        un;
    logic [34:0]        ud;
    logic               t_ge, t_cond;
    logic [FRAC_BITS-1:0] t_quo;
    logic               t_done;
    logic [ONE_W-1:0]   t_val;

    logic [31:0]        a_sel, b_sel;
    logic signed [32:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic [31:0]        lerp_res;
    logic [ONE_W+7:0]   t255;
    logic [7:0]         ti;
    logic signed [8:0]  cd;
    logic signed [17:0] cp;
    logic [31:0]        color_lerp;

    logic [31:0]        x_mag, y_mag, w_mag;
    logic [32:0]        qx, qy, qd;
    logic               ox, oy, od, dx, dy, dd;
    logic signed [31:0] sx_val, sy_val, rdep, dep_val;
    logic               w_zero;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg  <= '0;
            bias_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NEAR_EPS:   eps_reg  <= cfg_data[EPS_W-1:0];
                REG_DEPTH_BIAS: bias_reg <= $signed(cfg_data);
            endcase
        end
    end

    // in-front test for the three held vertices
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            near_dist[k] = 34'($signed(store_reg[k].w)) - 34'($signed(store_reg[k].z))
                           - $signed({17'b0, eps_reg});
            front_mask[k] = ~near_dist[k][33];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_en)
            store_reg[cmd.store_slot] <= in_vtx;
        if (cmd.rd_a)
            op_a_reg <= store_reg[cmd.rd_idx];
        if (cmd.rd_b)
            op_b_reg <= store_reg[cmd.rd_idx];
    end

    // edge weight set-up
    always_comb
    begin
        da = 34'($signed(op_a_reg.w)) - 34'($signed(op_a_reg.z)) - $signed({17'b0, eps_reg});
        db = 34'($signed(op_b_reg.w)) - 34'($signed(op_b_reg.z)) - $signed({17'b0, eps_reg});
        den = 35'(da) - 35'(db);
        un  = da[33] ? -da : da;
        ud  = den[34] ? -den : den;
        t_ge   = {1'b0, un} >= ud;
        t_cond = (den != '0) && (da != '0) && (da[33] == den[34]);
    end

    npc_div #(
        .NUM_W (FRAC_BITS),
        .DEN_W (35),
        .QUO_W (FRAC_BITS)
    ) u_div_t (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.t_start),
        .num      ('0),
        .den      (ud),
        .rem_init ({1'b0, un}),
        .done     (t_done),
        .quo      (t_quo),
        .ovf      ()
    );

    always_ff @(posedge clk)
    begin
        if (cmd.t_start)
        begin
            t_ge_reg   <= t_ge;
            t_cond_reg <= t_cond;
        end
    end

    always_comb
    begin
        if (!t_cond_reg)
            t_val = '0;
        else if (t_ge_reg)
            t_val = T_ONE;
        else
            t_val = {1'b0, t_quo};
    end

    // interpolation, one component per multiply/add pair
    always_comb
    begin
        case (cmd.comp)
            COMP_X:
            begin
                a_sel = op_a_reg.x;
                b_sel = op_b_reg.x;
            end
            COMP_Y:
            begin
                a_sel = op_a_reg.y;
                b_sel = op_b_reg.y;
            end
            COMP_W:
            begin
                a_sel = op_a_reg.w;
                b_sel = op_b_reg.w;
            end
            COMP_U:
            begin
                a_sel = op_a_reg.u;
                b_sel = op_b_reg.u;
            end
            COMP_V:
            begin
                a_sel = op_a_reg.v;
                b_sel = op_b_reg.v;
            end
            default:
            begin
                a_sel = '0;
                b_sel = '0;
            end
        endcase
        diff = 33'($signed(b_sel)) - 33'($signed(a_sel));
        prod = PROD_W'(diff) * PROD_W'($signed({1'b0, t_val}));
        // floor shift, then the low word of the sum
        lerp_res = a_sel + prod_reg[FRAC_BITS +: 32];

        t255 = {t_val, 8'b0} - (ONE_W + 8)'(t_val);
        ti   = t255[FRAC_BITS +: 8];
        for (int k = 0; k < 4; k++)
        begin
            cd = $signed({1'b0, op_b_reg.c[8*k +: 8]}) - $signed({1'b0, op_a_reg.c[8*k +: 8]});
            cp = 18'(cd) * $signed({10'b0, ti});
            color_lerp[8*k +: 8] = op_a_reg.c[8*k +: 8] + cp[15:8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= prod;
        if (cmd.rd_a)
        begin
            wx_reg <= store_reg[cmd.rd_idx].x;
            wy_reg <= store_reg[cmd.rd_idx].y;
            ww_reg <= store_reg[cmd.rd_idx].w;
            wu_reg <= store_reg[cmd.rd_idx].u;
            wv_reg <= store_reg[cmd.rd_idx].v;
            wc_reg <= store_reg[cmd.rd_idx].c;
        end
        else if (cmd.add_en)
        begin
            case (cmd.comp)
                COMP_X: wx_reg <= $signed(lerp_res);
                COMP_Y: wy_reg <= $signed(lerp_res);
                COMP_W: ww_reg <= $signed(lerp_res);
                COMP_U: wu_reg <= $signed(lerp_res);
                COMP_V:
                begin
                    wv_reg <= $signed(lerp_res);
                    wc_reg <= color_lerp;
                end
                default: ;
            endcase
        end
    end

    // perspective divide: x, y and depth share the divisor |w|
    always_comb
    begin
        x_mag  = wx_reg[31] ? -wx_reg : wx_reg;
        y_mag  = wy_reg[31] ? -wy_reg : wy_reg;
        w_mag  = ww_reg[31] ? -ww_reg : ww_reg;
        w_zero = (ww_reg == '0);
    end

    npc_div #(
        .NUM_W (NUM_W),
        .DEN_W (32),
        .QUO_W (33)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.e_start),
        .num      ({x_mag, {FRAC_BITS{1'b0}}}),
        .den      (w_mag),
        .rem_init ('0),
        .done     (dx),
        .quo      (qx),
        .ovf      (ox)
    );

    npc_div #(
        .NUM_W (NUM_W),
        .DEN_W (32),
        .QUO_W (33)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.e_start),
        .num      ({y_mag, {FRAC_BITS{1'b0}}}),
        .den      (w_mag),
        .rem_init ('0),
        .done     (dy),
        .quo      (qy),
        .ovf      (oy)
    );

    npc_div #(
        .NUM_W (NUM_W),
        .DEN_W (32),
        .QUO_W (33)
    ) u_div_d (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.e_start),
        .num      (DEPTH_NUM),
        .den      (w_mag),
        .rem_init ('0),
        .done     (dd),
        .quo      (qd),
        .ovf      (od)
    );

    always_comb
    begin
        // zero w: saturate toward the numerator's sign
        if (w_zero)
        begin
            sx_val = (wx_reg == '0) ? '0 : (wx_reg[31] ? I32_MIN : I32_MAX);
            sy_val = (wy_reg == '0) ? '0 : (wy_reg[31] ? I32_MIN : I32_MAX);
            rdep   = I32_MAX;
        end
        else
        begin
            sx_val = npc_sat_quo(qx, ox, wx_reg[31] ^ ww_reg[31]);
            sy_val = npc_sat_quo(qy, oy, wy_reg[31] ^ ww_reg[31]);
            rdep   = npc_sat_quo(qd, od, ww_reg[31]);
        end
        dep_val = npc_sat33(33'(rdep) + 33'(bias_reg));
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (cmd.out_load)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            sx_reg  <= sx_val;
            sy_reg  <= sy_val;
            dep_reg <= dep_val;
            ou_reg  <= wu_reg;
            ov_reg  <= wv_reg;
            oc_reg  <= wc_reg;
            eos_reg <= cmd.out_last;
        end
    end

    assign stat.mask     = front_mask;
    assign stat.t_done   = t_done;
    assign stat.e_done   = dx & dy & dd;
    assign stat.out_free = ~res_valid_reg | res_ready;

    assign res_valid    = res_valid_reg;
    assign screen_x     = sx_reg;
    assign screen_y     = sy_reg;
    assign depth        = dep_reg;
    assign out_u        = ou_reg;
    assign out_v        = ov_reg;
    assign out_color    = oc_reg;
    assign end_of_strip = eos_reg;

endmodule

// ===== sv/npc_ctrl.sv =====
// Clipper sequencer: vertex grouping, per-slot plan, divider and interpolation steps.
// Depends on npc_pkg.
module npc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                vert_valid,
    output logic                vert_ready,
    input  npc_pkg::npc_stat_t  stat,
    output npc_pkg::npc_cmd_t   cmd
);

    import npc_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_CLASS  = 11'b00000000010,
        ST_LOAD_A = 11'b00000000100,
        ST_LOAD_B = 11'b00000001000,
        ST_TSTART = 11'b00000010000,
        ST_TDIV   = 11'b00000100000,
        ST_LMUL   = 11'b00001000000,
        ST_LADD   = 11'b00010000000,
        ST_ESTART = 11'b00100000000,
        ST_EDIV   = 11'b01000000000,
        ST_OUT    = 11'b10000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic [1:0] slot_reg, slot_next;
    logic [2:0] mask_reg, mask_next;
    comp_t      comp_reg, comp_next;
    plan_t      plan;
    logic [1:0] last_slot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            slot_reg  <= '0;
            mask_reg  <= '0;
            comp_reg  <= COMP_X;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            slot_reg  <= slot_next;
            mask_reg  <= mask_next;
            comp_reg  <= comp_next;
        end
    end

    always_comb
    begin
        plan      = npc_plan(mask_reg, slot_reg);
        last_slot = npc_last(mask_reg);

        state_next = state_reg;
        phase_next = phase_reg;
        slot_next  = slot_reg;
        mask_next  = mask_reg;
        comp_next  = comp_reg;
        vert_ready = 1'b0;

        cmd            = '0;
        cmd.comp       = comp_reg;
        cmd.store_slot = phase_reg[1] ? 2'd2 : phase_reg;
        cmd.rd_idx     = plan.a;
        cmd.out_last   = (slot_reg == last_slot);

        unique case (state_reg)
            ST_IDLE:
            begin
                vert_ready = 1'b1;
                if (vert_valid)
                begin
                    cmd.store_en = 1'b1;
                    if (phase_reg[1])
                    begin
                        phase_next = '0;
                        state_next = ST_CLASS;
                    end
                    else
                        phase_next = phase_reg + 2'd1;
                end
            end
            ST_CLASS:
            begin
                mask_next  = stat.mask;
                slot_next  = '0;
                state_next = (stat.mask == '0) ? ST_IDLE : ST_LOAD_A;
            end
            ST_LOAD_A:
            begin
                cmd.rd_a   = 1'b1;
                state_next = plan.cut ? ST_LOAD_B : ST_ESTART;
            end
            ST_LOAD_B:
            begin
                cmd.rd_b   = 1'b1;
                cmd.rd_idx = plan.b;
                state_next = ST_TSTART;
            end
            ST_TSTART:
            begin
                cmd.t_start = 1'b1;
                state_next  = ST_TDIV;
            end
            ST_TDIV:
            begin
                if (stat.t_done)
                begin
                    comp_next  = COMP_X;
                    state_next = ST_LMUL;
                end
            end
            ST_LMUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_LADD;
            end
            ST_LADD:
            begin
                cmd.add_en = 1'b1;
                if (comp_reg == COMP_V)
                    state_next = ST_ESTART;
                else
                begin
                    comp_next  = comp_t'(3'(comp_reg) + 3'd1);
                    state_next = ST_LMUL;
                end
            end
            ST_ESTART:
            begin
                cmd.e_start = 1'b1;
                state_next  = ST_EDIV;
            end
            ST_EDIV:
            begin
                if (stat.e_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (slot_reg == last_slot)
                        state_next = ST_IDLE;
                    else
                    begin
                        slot_next  = slot_reg + 2'd1;
                        state_next = ST_LOAD_A;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== sv/npc_checker.sv =====
// Port-level checks for the clipper, bound to the top level.
// Depends on near_plane_triangle_clipper only through the bind.
module npc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        vert_valid,
    input logic        vert_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [31:0] screen_x,
    input logic [31:0] depth,
    input logic        end_of_strip
);

    // a waiting result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(screen_x) && $stable(depth)
                                    && $stable(end_of_strip))
    else $error("result beat changed while stalled");

    // mid-triangle results: no new vertex taken
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !end_of_strip |-> !vert_ready)
    else $error("vertex taken while triangle still emitting");

    // taking a vertex never produces a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        vert_valid && vert_ready |=> !(res_valid && !$past(res_valid)))
    else $error("result appeared straight after a vertex beat");

    // a fresh result only appears while the input side is closed
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> !$past(vert_ready))
    else $error("result loaded while idle");

endmodule

bind near_plane_triangle_clipper npc_checker u_npc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .vert_valid   (vert_valid),
    .vert_ready   (vert_ready),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .screen_x     (screen_x),
    .depth        (depth),
    .end_of_strip (end_of_strip)
);
